FILE: src/tscb_pkg.sv
// ----------------------------------------------------------------------------
// tscb_pkg
// Shared types and constants for the text screen cursor buffer.
// ----------------------------------------------------------------------------
package tscb_pkg;

    // screen dimensions in cells, wide enough for 256
    localparam int DIM_W = 9;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 1'b1;

    localparam logic [5:0] HEIGHT_RESET = 6'd24;
    localparam logic [7:0] WIDTH_RESET  = 8'd80;

    localparam logic [7:0] NUL_CHAR = 8'h00;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;
    localparam int CURSOR_OUT_W = 12;

    typedef enum logic [3:0] {
        OP_FWD   = 4'd0,
        OP_BACK  = 4'd1,
        OP_UP    = 4'd2,
        OP_DOWN  = 4'd3,
        OP_HOME  = 4'd4,
        OP_END   = 4'd5,
        OP_MOVE  = 4'd6,
        OP_GET   = 4'd7,
        OP_PUT   = 4'd8,
        OP_CLEAR = 4'd9
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_SIZE,
        ST_MUL_OP,
        ST_EXEC,
        ST_CLEAR,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

FILE: src/text_screen_cursor_buffer.sv
// ----------------------------------------------------------------------------
// text_screen_cursor_buffer
// Character screen store with a linear cursor and a shared row multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one operation per beat (fwd, back, up, down, home, end,
//   move, get_at, put, clear). m_ channel returns one beat per operation:
//   the character under the cursor, the cursor index and a rejected flag.
//   cfg_wr_en/cfg_addr/cfg_wdata write screen height (0) and width (1);
//   write them only while the block is idle.
// Operation flow:
//   A cursor operation goes from accept to result by two passes
//   through the shared 9x9 multiplier (screen size, then row offset), one
//   update step, one registered memory read and the result load.
//   A new operation is accepted only after the previous one has finished.
//   Clear adds a fill of height*width cells; the fill writes one cell a cycle
//   through the single memory write port.
//   s_tready is high only while no operation is in progress.
// Reset:
//   aresetn (synchronous, active low) homes the cursor, restores 24 rows by
//   80 columns and empties the result register. Cell contents are not reset;
//   issue a clear before reading cells.
// Stall:
//   A finished result holds in the output register while m_tready is low;
//   the next operation is accepted meanwhile but its result waits for it.
// ----------------------------------------------------------------------------
module text_screen_cursor_buffer #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tscb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tscb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // op[3:0], row_pos[11:4], col_pos[19:12], char_in[27:20], zero[31:28]
    input  logic [tscb_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // char_out[7:0], cursor_index[19:8], out_of_range[20], zero[23:21]
    output logic [tscb_pkg::M_TDATA_W-1:0]    m_tdata
);
    import tscb_pkg::*;

    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int SIZE_W = $clog2(CELL_COUNT + 1);
    localparam int EXT_W  = (SIZE_W > CURSOR_OUT_W) ? SIZE_W : CURSOR_OUT_W;

    logic [7:0] cell_mem [CELL_COUNT];

    state_t state_reg, state_next;

    logic [5:0]        height_reg;
    logic [7:0]        width_reg;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    op_t               op_reg, op_next;
    logic [7:0]        rp_reg, rp_next;
    logic [7:0]        cp_reg, cp_next;
    logic [7:0]        ch_reg, ch_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] prod_reg, prod_next;
    logic [SIZE_W-1:0] clr_idx_reg, clr_idx_next;
    logic              flag_reg, flag_next;
    logic [7:0]        rd_data_reg;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_char_reg, m_char_next;
    logic [CURSOR_OUT_W-1:0] m_cursor_reg, m_cursor_next;
    logic              m_oor_reg, m_oor_next;

    logic [DIM_W-1:0]   h_raw, w_raw, h_eff, w_eff;
    logic [DIM_W-1:0]   mul_a;
    logic [2*DIM_W-1:0] mul_p;
    logic [SIZE_W-1:0]  cursor_ext, w_ext, last_idx;
    logic [EXT_W-1:0]   cursor_wide;
    logic               mem_we, rd_en, out_load;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [7:0]         mem_wdata;

    // clamp the screen dimensions into 1..MAX
    always_comb begin
        h_raw = DIM_W'(height_reg);
        w_raw = DIM_W'(width_reg);
        if (h_raw == '0) begin
            h_eff = DIM_W'(1);
        end else if (h_raw > DIM_W'(MAX_ROWS)) begin
            h_eff = DIM_W'(MAX_ROWS);
        end else begin
            h_eff = h_raw;
        end
        if (w_raw == '0) begin
            w_eff = DIM_W'(1);
        end else if (w_raw > DIM_W'(MAX_COLS)) begin
            w_eff = DIM_W'(MAX_COLS);
        end else begin
            w_eff = w_raw;
        end
    end

    assign mul_p       = (2*DIM_W)'(mul_a) * (2*DIM_W)'(w_eff);
    assign cursor_ext  = SIZE_W'(cursor_reg);
    assign w_ext       = SIZE_W'(w_eff);
    assign last_idx    = size_reg - SIZE_W'(1);
    assign cursor_wide = EXT_W'(cursor_reg);
    assign out_load    = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        op_next       = op_reg;
        rp_next       = rp_reg;
        cp_next       = cp_reg;
        ch_next       = ch_reg;
        size_next     = size_reg;
        prod_next     = prod_reg;
        clr_idx_next  = clr_idx_reg;
        flag_next     = flag_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_char_next   = m_char_reg;
        m_cursor_next = m_cursor_reg;
        m_oor_next    = m_oor_reg;
        s_tready      = 1'b0;
        mul_a         = '0;
        mem_we        = 1'b0;
        mem_waddr     = cursor_reg;
        mem_wdata     = ch_reg;
        rd_en         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next    = op_t'(s_tdata[3:0]);
                    rp_next    = s_tdata[11:4];
                    cp_next    = s_tdata[19:12];
                    ch_next    = s_tdata[27:20];
                    state_next = ST_MUL_SIZE;
                end
            end
            ST_MUL_SIZE: begin
                mul_a      = h_eff;
                size_next  = SIZE_W'(mul_p);
                state_next = ST_MUL_OP;
            end
            ST_MUL_OP: begin
                if (op_reg == OP_DOWN) begin
                    mul_a = h_eff - DIM_W'(1);
                end else begin
                    mul_a = DIM_W'(rp_reg) - DIM_W'(1);
                end
                prod_next  = SIZE_W'(mul_p);
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                flag_next  = 1'b0;
                state_next = ST_READ;
                case (op_reg)
                    OP_FWD: begin
                        if (cursor_ext + SIZE_W'(1) >= size_reg) begin
                            cursor_next = '0;
                        end else begin
                            cursor_next = ADDR_W'(cursor_ext + SIZE_W'(1));
                        end
                    end
                    OP_BACK: begin
                        if (cursor_ext == '0) begin
                            cursor_next = ADDR_W'(last_idx);
                        end else begin
                            cursor_next = ADDR_W'(cursor_ext - SIZE_W'(1));
                        end
                    end
                    OP_UP: begin
                        if (cursor_ext < w_ext) begin
                            cursor_next = ADDR_W'(last_idx);
                        end else begin
                            cursor_next = ADDR_W'(cursor_ext - w_ext);
                        end
                    end
                    OP_DOWN: begin
                        if (cursor_ext >= prod_reg) begin
                            cursor_next = '0;
                        end else begin
                            cursor_next = ADDR_W'(cursor_ext + w_ext);
                        end
                    end
                    OP_HOME: begin
                        cursor_next = '0;
                    end
                    OP_END: begin
                        cursor_next = ADDR_W'(last_idx);
                    end
                    OP_MOVE, OP_GET: begin
                        if (rp_reg == '0 || DIM_W'(rp_reg) > h_eff ||
                            cp_reg == '0 || DIM_W'(cp_reg) > w_eff) begin
                            flag_next = 1'b1;
                        end else begin
                            cursor_next = ADDR_W'(prod_reg + SIZE_W'(cp_reg) - SIZE_W'(1));
                        end
                    end
                    OP_PUT: begin
                        mem_we = (ch_reg != NUL_CHAR);
                    end
                    OP_CLEAR: begin
                        cursor_next  = '0;
                        clr_idx_next = '0;
                        state_next   = ST_CLEAR;
                    end
                    default: begin
                    end
                endcase
            end
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(clr_idx_reg);
                if (clr_idx_reg == last_idx) begin
                    state_next = ST_READ;
                end else begin
                    clr_idx_next = clr_idx_reg + SIZE_W'(1);
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = rd_data_reg;
                    m_cursor_next = cursor_wide[CURSOR_OUT_W-1:0];
                    m_oor_next    = flag_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cursor_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cursor_reg   <= cursor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= HEIGHT_RESET;
            width_reg  <= WIDTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HEIGHT: height_reg <= cfg_wdata[5:0];
                REG_WIDTH:  width_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        rp_reg       <= rp_next;
        cp_reg       <= cp_next;
        ch_reg       <= ch_next;
        size_reg     <= size_next;
        prod_reg     <= prod_next;
        clr_idx_reg  <= clr_idx_next;
        flag_reg     <= flag_next;
        m_char_reg   <= m_char_next;
        m_cursor_reg <= m_cursor_next;
        m_oor_reg    <= m_oor_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= cell_mem[cursor_reg];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_oor_reg, m_cursor_reg, m_char_reg};

`ifndef SYNTHESIS
    a_oor_only_positional: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && flag_reg) |-> (op_reg == OP_MOVE || op_reg == OP_GET))
        else $error("out_of_range raised for a non-positional operation");

    a_clear_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (clr_idx_reg < size_reg))
        else $error("clear sweep ran past the screen");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result beat raised outside the result load");
`endif

endmodule
